// File: rtl/rcg_pkg.sv
// Shared types and constants for the template random character generator.
// No dependencies; every module imports this package.
package rcg_pkg;

  // Generator step: state * LCG_MUL + LCG_ADD, modulo 2^32.
  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;
  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam int DRAW_W = 15;
  localparam int DRAW_LSB = 16;

  // Reciprocals for the remainder unit, exact for any 15-bit draw.
  localparam int RECIP_SHIFT = 20;
  localparam logic [16:0] RECIP10 = 17'd104858;
  localparam logic [15:0] RECIP26 = 16'd40330;

  // Template codes.
  localparam logic [7:0] TPL_DIGIT = 8'h3F;
  localparam logic [7:0] TPL_UPPER = 8'hBA;
  localparam logic [7:0] TPL_LOWER = 8'h21;
  localparam logic [7:0] TPL_LETTER = 8'h23;
  localparam logic [7:0] TPL_ANY = 8'h2A;

  // Character bases.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_HOLD
  } seq_state_e;

  // What the next draw decides.
  typedef enum logic [2:0] {
    K_DIGIT,
    K_UPPER,
    K_LOWER,
    K_CASE,
    K_ANY
  } draw_kind_e;

  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
  } lcg_ctl_t;

  typedef struct packed {
    logic       lsb;
    logic [3:0] rem10;
    logic [4:0] rem26;
  } draw_rem_t;

endpackage

// File: rtl/rcg_tpl_if.sv
// Template byte request channel.
// Depends on nothing.
interface rcg_tpl_if;
  logic       valid;
  logic       ready;
  logic [7:0] template_byte;

  modport source (output valid, output template_byte, input ready);
  modport sink (input valid, input template_byte, output ready);
endinterface

// File: rtl/rcg_res_if.sv
// Result byte request channel.
// Depends on nothing.
interface rcg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

// File: rtl/rcg_lcg.sv
// Shared generator unit: 32-bit state register, one multiply-add step per cycle while step is set.
// Depends on rcg_pkg.
module rcg_lcg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcg_pkg::lcg_ctl_t ctl_i,
  output logic [14:0]       draw_o
);
  import rcg_pkg::*;

  logic [31:0] state_q, state_d;
  logic [31:0] step_val;

  assign step_val = state_q * LCG_MUL + LCG_ADD;

  always_comb begin
    state_d = state_q;
    if (ctl_i.load) begin
      state_d = ctl_i.seed;
    end else if (ctl_i.step) begin
      state_d = step_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  assign draw_o = state_q[DRAW_LSB +: DRAW_W];

endmodule

// File: rtl/rcg_mod.sv
// Remainder unit: draw modulo 10 and 26 by reciprocal multiply, plus draw parity.
// Depends on rcg_pkg.
module rcg_mod (
  input  logic [14:0]        draw_i,
  output rcg_pkg::draw_rem_t rem_o
);
  import rcg_pkg::*;

  logic [31:0] p10;
  logic [30:0] p26;
  logic [11:0] q10;
  logic [10:0] q26;
  logic [14:0] q10x, q26x, r10, r26;

  assign p10 = {15'd0, draw_i} * {15'd0, RECIP10};
  assign p26 = {16'd0, draw_i} * {15'd0, RECIP26};
  assign q10 = p10[RECIP_SHIFT +: 12];
  assign q26 = p26[RECIP_SHIFT +: 11];

  // q*10 and q*26 as shift-add
  assign q10x = {q10[11:0], 3'd0} + {2'd0, q10, 1'b0};
  assign q26x = {q26[10:0], 4'd0} + {1'b0, q26, 3'd0} + {3'd0, q26, 1'b0};
  assign r10 = draw_i - q10x;
  assign r26 = draw_i - q26x;

  assign rem_o.lsb = draw_i[0];
  assign rem_o.rem10 = r10[3:0];
  assign rem_o.rem26 = r26[4:0];

endmodule

// File: rtl/rcg_seq.sv
// Sequencer: decodes the template byte, steps the generator per draw, holds the result.
// Depends on rcg_pkg, rcg_tpl_if, rcg_res_if.
module rcg_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  rcg_tpl_if.sink            tpl,
  rcg_res_if.source          res,
  input  rcg_pkg::draw_rem_t rem_i,
  output logic               step_o
);
  import rcg_pkg::*;

  seq_state_e state_q, state_d;
  draw_kind_e kind_q, kind_d;
  logic [7:0] hold_q, hold_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;
  logic [7:0] fin_val;

  assign can_load = !out_valid_q || res.ready;

  always_comb begin
    case (kind_q)
      K_DIGIT: fin_val = CH_ZERO + {4'd0, rem_i.rem10};
      K_UPPER: fin_val = CH_UPPER_A + {3'd0, rem_i.rem26};
      K_LOWER: fin_val = CH_LOWER_A + {3'd0, rem_i.rem26};
      default: fin_val = CH_ZERO;
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    hold_d = hold_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !res.ready;
    step_o = 1'b0;
    tpl.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (tpl.valid) begin
          step_o = 1'b1;
          state_d = S_DRAW;
          case (tpl.template_byte)
            TPL_DIGIT: kind_d = K_DIGIT;
            TPL_UPPER: kind_d = K_UPPER;
            TPL_LOWER: kind_d = K_LOWER;
            TPL_LETTER: kind_d = K_CASE;
            TPL_ANY: kind_d = K_ANY;
            default: begin
              // literal: no draw, to the output, or to the hold register if the output is stalled
              step_o = 1'b0;
              if (can_load) begin
                out_valid_d = 1'b1;
                out_data_d = tpl.template_byte;
                state_d = S_IDLE;
              end else begin
                hold_d = tpl.template_byte;
                state_d = S_HOLD;
              end
            end
          endcase
        end
      end
      S_DRAW: begin
        case (kind_q)
          K_CASE: begin
            kind_d = rem_i.lsb ? K_UPPER : K_LOWER;
            step_o = 1'b1;
          end
          K_ANY: begin
            kind_d = rem_i.lsb ? K_DIGIT : K_CASE;
            step_o = 1'b1;
          end
          default: begin
            if (can_load) begin
              out_valid_d = 1'b1;
              out_data_d = fin_val;
              state_d = S_IDLE;
            end else begin
              hold_d = fin_val;
              state_d = S_HOLD;
            end
          end
        endcase
      end
      S_HOLD: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_data_d = hold_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    hold_q <= hold_d;
    out_data_q <= out_data_d;
  end

  assign res.valid = out_valid_q;
  assign res.result_byte = out_data_q;

  a_literal_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tpl.valid && tpl.ready && !step_o && can_load)
    |=> (res.valid && res.result_byte == $past(tpl.template_byte)))
    else $error("literal byte not forwarded");

  a_final_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW && (kind_q == K_DIGIT || kind_q == K_UPPER || kind_q == K_LOWER))
    |-> !step_o)
    else $error("generator stepped on a final draw");

  a_idle_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DRAW && !(tpl.valid && tpl.ready)) |-> !step_o)
    else $error("generator stepped without a request");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW && kind_q == K_DIGIT && can_load)
    |=> (res.result_byte >= CH_ZERO && res.result_byte <= CH_ZERO + 8'd9))
    else $error("digit out of range");

endmodule

// File: rtl/template_random_char_generator.sv
// Top level of the template random character generator.
// Depends on rcg_pkg, rcg_tpl_if, rcg_res_if, rcg_lcg, rcg_mod, rcg_seq.
//
//   channel  direction  payload              handshake
//   tpl_i    in         template_byte [7:0]  valid/ready
//   res_o    out        result_byte   [7:0]  valid/ready
//   cfg      in         cfg_wdata_i  [31:0]  cfg_we_i, seed, no read-back
//
// Draws per byte: literal none, '?' / 0xBA / '!' one, '#' two, '*' two or three.
// Each draw is one pass through the shared generator multiply-add unit.
// tpl_i.ready is high only while the sequencer is idle.
// A stalled res_o holds its byte; one more finished byte waits in the sequencer.
// Reset loads the generator with 1; a seed write reloads it at once.
module template_random_char_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rcg_tpl_if.sink     tpl_i,
  rcg_res_if.source   res_o
);
  import rcg_pkg::*;

  lcg_ctl_t    lcg_ctl;
  draw_rem_t   rem;
  logic [14:0] draw;
  logic        step;

  assign lcg_ctl.load = cfg_we_i;
  assign lcg_ctl.step = step;
  assign lcg_ctl.seed = cfg_wdata_i;

  rcg_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lcg_ctl),
    .draw_o (draw)
  );

  rcg_mod u_mod (
    .draw_i (draw),
    .rem_o  (rem)
  );

  rcg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tpl    (tpl_i),
    .res    (res_o),
    .rem_i  (rem),
    .step_o (step)
  );

endmodule
